// ===== design/kpq_pkg.sv =====
package kpq_pkg;

    localparam int PIN_W   = 6;
    localparam int COUNT_W = 9;
    localparam int TIMER_W = 16;
    localparam int THR_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_TICKS  = 3'd4;

    // register reset values
    localparam logic [THR_W-1:0]   RST_SHORT_PRESS = 8'd3;
    localparam logic [THR_W-1:0]   RST_LONG_PRESS  = 8'd100;
    localparam logic [THR_W-1:0]   RST_REPEAT      = 8'd20;
    localparam logic [PIN_W-1:0]   RST_IDLE        = 6'd0;
    localparam logic [TIMER_W-1:0] RST_WAKE_TICKS  = 16'd300;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic [THR_W-1:0]   short_press_count;
        logic [THR_W-1:0]   long_press_count;
        logic [THR_W-1:0]   repeat_spacing;
        logic [PIN_W-1:0]   idle_pattern;
        logic [TIMER_W-1:0] wake_mask_ticks;
    } cfg_t;

    typedef struct packed {
        logic [PIN_W-1:0] key_code;
        event_kind_t      event_kind;
        logic             backlight_wake;
    } result_t;

endpackage

// ===== design/kpq_cfg_regs.sv =====
module kpq_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [kpq_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [kpq_pkg::CFG_DATA_W-1:0]   wr_data,
    output kpq_pkg::cfg_t                    cfg
);

    kpq_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_press_count <= kpq_pkg::RST_SHORT_PRESS;
            cfg_reg.long_press_count  <= kpq_pkg::RST_LONG_PRESS;
            cfg_reg.repeat_spacing    <= kpq_pkg::RST_REPEAT;
            cfg_reg.idle_pattern      <= kpq_pkg::RST_IDLE;
            cfg_reg.wake_mask_ticks   <= kpq_pkg::RST_WAKE_TICKS;
        end
        else if (wr_en)
        begin
            case (wr_index)
                kpq_pkg::CFG_SHORT_PRESS:
                    cfg_reg.short_press_count <= wr_data[kpq_pkg::THR_W-1:0];
                kpq_pkg::CFG_LONG_PRESS:
                    cfg_reg.long_press_count  <= wr_data[kpq_pkg::THR_W-1:0];
                kpq_pkg::CFG_REPEAT:
                    cfg_reg.repeat_spacing    <= wr_data[kpq_pkg::THR_W-1:0];
                kpq_pkg::CFG_IDLE:
                    cfg_reg.idle_pattern      <= wr_data[kpq_pkg::PIN_W-1:0];
                kpq_pkg::CFG_WAKE_TICKS:
                    cfg_reg.wake_mask_ticks   <= wr_data[kpq_pkg::TIMER_W-1:0];
                default:
                begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/kpq_core.sv =====
module kpq_core
#(
    parameter logic [5:0] KEY_MASK = 6'h3F
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [kpq_pkg::PIN_W-1:0]     pin_levels,
    input  logic                          backlight_on,
    input  kpq_pkg::cfg_t                 cfg,
    output kpq_pkg::result_t              result
);

    logic [kpq_pkg::PIN_W-1:0]   held_pattern_reg, held_pattern_next;
    logic [kpq_pkg::COUNT_W-1:0] hold_count_reg, hold_count_next;
    logic                        wake_mask_reg, wake_mask_next;
    logic [kpq_pkg::TIMER_W-1:0] mask_timer_reg, mask_timer_next;

    logic [kpq_pkg::PIN_W-1:0]   pressed;
    logic [kpq_pkg::PIN_W-1:0]   pattern;
    logic [kpq_pkg::COUNT_W-1:0] count_inc;
    logic [kpq_pkg::COUNT_W-1:0] long_thr;

    always_comb
    begin
        held_pattern_next     = held_pattern_reg;
        hold_count_next       = hold_count_reg;
        wake_mask_next        = wake_mask_reg;
        mask_timer_next       = mask_timer_reg;
        pattern               = '0;
        result.key_code       = '0;
        result.event_kind     = kpq_pkg::EV_NONE;
        result.backlight_wake = 1'b0;

        // hold-off timer runs first
        if (wake_mask_reg)
        begin
            if (mask_timer_reg <= kpq_pkg::TIMER_W'(1))
            begin
                wake_mask_next  = 1'b0;
                mask_timer_next = '0;
            end
            else
            begin
                mask_timer_next = mask_timer_reg - kpq_pkg::TIMER_W'(1);
            end
        end

        pressed = ~pin_levels & KEY_MASK;
        if (!wake_mask_next && pressed != '0)
        begin
            if (backlight_on)
            begin
                pattern = pressed;
            end
            else
            begin
                // dark panel: the press only wakes the backlight
                result.backlight_wake = 1'b1;
                wake_mask_next        = 1'b1;
                mask_timer_next       = cfg.wake_mask_ticks;
            end
        end

        count_inc = (hold_count_reg < kpq_pkg::COUNT_MAX) ?
                    hold_count_reg + kpq_pkg::COUNT_W'(1) : hold_count_reg;
        long_thr  = kpq_pkg::COUNT_W'(cfg.long_press_count) +
                    kpq_pkg::COUNT_W'(cfg.repeat_spacing);

        if (pattern != held_pattern_reg)
        begin
            result.backlight_wake = 1'b1;
            if (hold_count_reg > kpq_pkg::COUNT_W'(cfg.short_press_count) &&
                hold_count_reg <= kpq_pkg::COUNT_W'(cfg.long_press_count))
            begin
                // report the release; adopt the new pattern on the next tick
                result.key_code   = held_pattern_reg;
                result.event_kind = kpq_pkg::EV_SHORT;
            end
            else
            begin
                held_pattern_next = pattern;
            end
            hold_count_next = '0;
        end
        else if (held_pattern_reg != cfg.idle_pattern)
        begin
            hold_count_next = count_inc;
            if (count_inc > long_thr)
            begin
                hold_count_next       = count_inc - kpq_pkg::COUNT_W'(cfg.repeat_spacing);
                result.backlight_wake = 1'b1;
                result.key_code       = held_pattern_reg;
                result.event_kind     = kpq_pkg::EV_LONG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_pattern_reg <= kpq_pkg::RST_IDLE;
            hold_count_reg   <= '0;
            wake_mask_reg    <= 1'b0;
            mask_timer_reg   <= '0;
        end
        else if (step)
        begin
            held_pattern_reg <= held_pattern_next;
            hold_count_reg   <= hold_count_next;
            wake_mask_reg    <= wake_mask_next;
            mask_timer_reg   <= mask_timer_next;
        end
    end

endmodule

// ===== design/key_press_qualifier_unit.sv =====
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    scan tick: pin levels, backlight flag
// m_        out        m_tvalid/m_tready    one result per tick: key code, event, wake
// cfg_      in         cfg_valid/cfg_ready  register index and write data
//
// One tick per cycle sustained while m_tready holds: a tick waits in the input register,
// the qualifier logic updates its state as the tick moves into the result register,
// and m_tvalid is driven straight from the result register's valid flag.
// Reset clears both stages, the scanner state and loads register defaults.
// A stalled result holds the result register; the input register still takes a
// tick while its contents can advance, so at most two ticks are in flight.
module key_press_qualifier_unit
#(
    parameter int NUM_KEYS = 6
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [5:0] pin_levels, [7:6] zero
    input  logic                             s_tuser,   // [0] backlight_on
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [5:0] key_code, [7:6] zero
    output logic [2:0]                       m_tuser,   // [1:0] event_kind, [2] backlight_wake
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kpq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kpq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int KEY_BITS = (NUM_KEYS < kpq_pkg::PIN_W) ? NUM_KEYS : kpq_pkg::PIN_W;
    localparam logic [kpq_pkg::PIN_W-1:0] KEY_MASK =
        kpq_pkg::PIN_W'(((kpq_pkg::PIN_W + 1)'(1) << KEY_BITS) - (kpq_pkg::PIN_W + 1)'(1));

    kpq_pkg::cfg_t    cfg;
    kpq_pkg::result_t result;

    logic                      in_valid_reg;
    logic [kpq_pkg::PIN_W-1:0] in_pins_reg;
    logic                      in_lit_reg;
    logic                      out_valid_reg;
    kpq_pkg::result_t          out_reg;
    logic                      advance;
    logic                      s_accept;

    assign cfg_ready = 1'b1;

    kpq_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    kpq_core #(.KEY_MASK(KEY_MASK)) u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .pin_levels   (in_pins_reg),
        .backlight_on (in_lit_reg),
        .cfg          (cfg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_pins_reg <= s_tdata[kpq_pkg::PIN_W-1:0];
            in_lit_reg  <= s_tuser;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.key_code};
    assign m_tuser  = {out_reg.backlight_wake, out_reg.event_kind};

    // a tick leaving the input stage always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
    else $error("tick lost between input and result stage");

    // an empty result register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
    else $error("input stalled with empty result register");

    // no event means no key code, and every event also requests a wake
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.event_kind == kpq_pkg::EV_NONE |-> out_reg.key_code == '0)
    else $error("key code reported without event");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.event_kind != kpq_pkg::EV_NONE |-> out_reg.backlight_wake)
    else $error("event without backlight wake");

endmodule
